// ----- design/wpe_pkg.sv -----
// wpe_pkg: shared types and constants of the waveform peak envelope core
// no dependencies

package wpe_pkg;

    // operation codes carried in s_tuser
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // status codes carried in m_tuser
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_PROBE = 1'b1;

    // configuration register indexes
    localparam logic [7:0] REG_HOP_LENGTH    = 8'd0;
    localparam logic [7:0] REG_CHANNEL_COUNT = 8'd1;

    // parameter defaults
    localparam int DEF_PEAK_DEPTH  = 4096;
    localparam int DEF_SAMPLE_BITS = 16;

    // register widths and reset values
    localparam int HOP_W = 17;
    localparam int CH_W  = 4;
    localparam logic [HOP_W-1:0] HOP_RESET = 17'd256;
    localparam logic [CH_W-1:0]  CH_RESET  = 4'd2;
    localparam logic [HOP_W-1:0] HOP_MAX   = 17'd65536;
    localparam logic [CH_W-1:0]  CH_MAX    = 4'd8;

    // running sample counter
    localparam int CNT_W = 20;

    // query field widths
    localparam int QPOS_W = 32;
    localparam int NP_W   = 16;
    localparam int K_W    = 15;
    localparam int QRY_W  = 2 * QPOS_W + NP_W + K_W;

    // shared divider
    localparam int DIV_NUM_W = 47;
    localparam int DIV_DEN_W = 17;

    typedef struct packed {
        logic [K_W-1:0]    probe_index;
        logic [NP_W-1:0]   probe_count;
        logic [QPOS_W-1:0] query_length;
        logic [QPOS_W-1:0] query_start;
    } query_t;

endpackage

// ----- design/wpe_ram.sv -----
// wpe_ram: generic single write, single read ram with registered read data
// no dependencies

module wpe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/wpe_front.sv -----
// wpe_front: input stream acceptance and a two word queue toward the back end
// depends on wpe_pkg

module wpe_front #(
    parameter int SAMPLE_BITS = wpe_pkg::DEF_SAMPLE_BITS,
    parameter int IN_W        = SAMPLE_BITS + wpe_pkg::QRY_W,
    parameter int IN_TW       = ((IN_W + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TW-1:0]       s_tdata,
    input  logic                   s_tuser,
    output logic                   item_valid,
    input  logic                   item_ready,
    output logic                   item_op,
    output logic [SAMPLE_BITS-1:0] item_sample,
    output wpe_pkg::query_t        item_query
);

    localparam int ENT_W = IN_W + 1;

    logic [ENT_W-1:0] slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push_in, pop_out;
    logic [ENT_W-1:0] head;

    assign s_tready   = (fill_reg != 2'd2);
    assign item_valid = (fill_reg != 2'd0);
    assign push_in    = s_tvalid && s_tready;
    assign pop_out    = item_valid && item_ready;

    assign head        = slot_reg[rptr_reg];
    assign item_op     = head[IN_W];
    assign item_sample = head[SAMPLE_BITS-1:0];
    assign item_query  = wpe_pkg::query_t'(head[IN_W-1:SAMPLE_BITS]);

    always_comb
    begin
        wptr_next = wptr_reg ^ push_in;
        rptr_next = rptr_reg ^ pop_out;
        fill_next = fill_reg + 2'(push_in) - 2'(pop_out);
    end

    always_ff @(posedge clk)
    begin
        if (push_in)
        begin
            slot_reg[wptr_reg] <= {s_tuser, s_tdata[IN_W-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ----- design/wpe_div.sv -----
// wpe_div: unsigned restoring divider, one quotient bit per cycle
// depends on wpe_pkg

module wpe_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            go,
    input  logic [wpe_pkg::DIV_NUM_W-1:0]   num,
    input  logic [wpe_pkg::DIV_DEN_W-1:0]   den,
    output logic                            done,
    output logic [wpe_pkg::DIV_NUM_W-1:0]   quot
);

    localparam int NW = wpe_pkg::DIV_NUM_W;
    localparam int DW = wpe_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] num_reg, num_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   shifted;
    logic          ge;

    assign done = done_reg;
    assign quot = num_reg;

    always_comb
    begin
        shifted   = {rem_reg, num_reg[NW-1]};
        ge        = (shifted >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DW'(shifted - {1'b0, den_reg}) : DW'(shifted);
            num_next = {num_reg[NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ----- design/wpe_back.sv -----
// wpe_back: executes pushes and probe queries, owns the peak store and result word
// depends on wpe_pkg, wpe_ram, wpe_div

module wpe_back #(
    parameter int PEAK_DEPTH  = wpe_pkg::DEF_PEAK_DEPTH,
    parameter int SAMPLE_BITS = wpe_pkg::DEF_SAMPLE_BITS,
    parameter int CW          = $clog2(PEAK_DEPTH + 1),
    parameter int OUT_TW      = ((16 + CW + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [wpe_pkg::HOP_W-1:0]     hop_eff,
    input  logic [wpe_pkg::CNT_W-1:0]     hop_total,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          item_op,
    input  logic [SAMPLE_BITS-1:0]        item_sample,
    input  wpe_pkg::query_t               item_query,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_TW-1:0]             m_tdata,
    output logic                          m_tuser
);

    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(PEAK_DEPTH);
    localparam int NW = wpe_pkg::DIV_NUM_W;
    localparam int DW = wpe_pkg::DIV_DEN_W;
    localparam int PW = SB + 8;
    localparam int LW = wpe_pkg::QPOS_W - 1;
    localparam int KW = wpe_pkg::K_W;
    localparam int XW = NW + 1;
    localparam logic signed [SB-1:0] FS_POS = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] FS_NEG = {1'b1, {(SB-1){1'b0}}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_DIV1  = 4'd2;
    localparam logic [3:0] S_DIV2  = 4'd3;
    localparam logic [3:0] S_POS   = 4'd4;
    localparam logic [3:0] S_DIV3  = 4'd5;
    localparam logic [3:0] S_DIV4  = 4'd6;
    localparam logic [3:0] S_CHECK = 4'd7;
    localparam logic [3:0] S_RADDR = 4'd8;
    localparam logic [3:0] S_RDATA = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    function automatic logic signed [7:0] scale8(input logic signed [SB-1:0] v);
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] q;
        p = PW'(v) * $signed(PW'(127));
        if (p < 0)
        begin
            p = p + $signed(PW'(FS_POS));
        end
        q = p >>> (SB - 1);
        if (q > $signed(PW'(127)))
        begin
            q = PW'(127);
        end
        if (q < -$signed(PW'(128)))
        begin
            q = -$signed(PW'(128));
        end
        return q[7:0];
    endfunction

    // state and running values
    logic [3:0]               state_reg, state_next;
    logic signed [SB-1:0]     rmin_reg, rmin_next;
    logic signed [SB-1:0]     rmax_reg, rmax_next;
    logic [wpe_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]            pc_reg, pc_next;

    // query work registers
    logic signed [31:0] start_reg, start_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [KW-1:0]      np_reg, np_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [NW-2:0]      prod_reg, prod_next;
    logic [NW-1:0]      q1_reg, q1_next;
    logic signed [XW-1:0] s_reg, s_next;
    logic signed [XW-1:0] e_reg, e_next;
    logic [NW-1:0]      lpos_reg, lpos_next;
    logic [NW-1:0]      i0_reg, i0_next;
    logic [NW-1:0]      i1_reg, i1_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      end_reg, end_next;
    logic               any_reg, any_next;
    logic signed [7:0]  amin_reg, amin_next;
    logic signed [7:0]  amax_reg, amax_next;
    logic               stat_reg, stat_next;

    // divider handshake
    logic          div_go_reg, div_go_next;
    logic [NW-1:0] div_num_reg, div_num_next;
    logic [DW-1:0] div_den_reg, div_den_next;
    logic          div_done;
    logic [NW-1:0] div_quot;

    // output word
    logic              ovalid_reg, ovalid_next;
    logic [OUT_TW-1:0] odata_reg, odata_next;
    logic              ouser_reg, ouser_next;

    // combinational helpers
    logic signed [SB-1:0] pmin, pmax;
    logic [wpe_pkg::CNT_W-1:0] cnt_inc;
    logic                 we;
    logic [15:0]          wdata;
    logic [15:0]          rdata;
    logic [NW-2:0]        prod;
    logic signed [XW-1:0] last;
    logic [NW-1:0]        i1c;
    logic [NW-1:0]        pc_ext;
    logic signed [7:0]    emin, emax;
    logic                 out_free;

    assign item_ready = (state_reg == S_IDLE);
    assign m_tvalid   = ovalid_reg;
    assign m_tdata    = odata_reg;
    assign m_tuser    = ouser_reg;
    assign out_free   = !ovalid_reg || m_tready;

    wpe_ram #(
        .WIDTH (16),
        .DEPTH (PEAK_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (pc_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    wpe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next   = state_reg;
        rmin_next    = rmin_reg;
        rmax_next    = rmax_reg;
        cnt_next     = cnt_reg;
        pc_next      = pc_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        np_next      = np_reg;
        k_next       = k_reg;
        prod_next    = prod_reg;
        q1_next      = q1_reg;
        s_next       = s_reg;
        e_next       = e_reg;
        lpos_next    = lpos_reg;
        i0_next      = i0_reg;
        i1_next      = i1_reg;
        idx_next     = idx_reg;
        end_next     = end_reg;
        any_next     = any_reg;
        amin_next    = amin_reg;
        amax_next    = amax_reg;
        stat_next    = stat_reg;
        div_go_next  = 1'b0;
        div_num_next = div_num_reg;
        div_den_next = div_den_reg;
        ovalid_next  = ovalid_reg && !m_tready;
        odata_next   = odata_reg;
        ouser_next   = ouser_reg;
        we           = 1'b0;

        // push datapath
        pmin    = ($signed(item_sample) < rmin_reg) ? $signed(item_sample) : rmin_reg;
        pmax    = ($signed(item_sample) > rmax_reg) ? $signed(item_sample) : rmax_reg;
        cnt_inc = cnt_reg + 1'b1;
        wdata   = {scale8(pmin), scale8(pmax)};

        prod   = (NW-1)'(k_reg) * (NW-1)'(len_reg);
        last   = (e_reg > s_reg) ? (e_reg - XW'(1)) : s_reg;
        pc_ext = NW'(pc_reg);
        i1c    = (i1_reg >= pc_ext) ? (pc_ext - NW'(1)) : i1_reg;
        emin   = $signed(rdata[15:8]);
        emax   = $signed(rdata[7:0]);

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item_op == wpe_pkg::OP_PUSH)
                    begin
                        rmin_next = pmin;
                        rmax_next = pmax;
                        cnt_next  = cnt_inc;
                        if (cnt_inc >= hop_total)
                        begin
                            if (pc_reg < CW'(PEAK_DEPTH))
                            begin
                                we      = 1'b1;
                                pc_next = pc_reg + 1'b1;
                            end
                            rmin_next = FS_POS;
                            rmax_next = FS_NEG;
                            cnt_next  = '0;
                        end
                    end
                    else if ($signed(item_query.probe_count) < $signed(16'sd1))
                    begin
                        stat_next  = wpe_pkg::STATUS_BAD_PROBE;
                        amin_next  = '0;
                        amax_next  = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        stat_next  = wpe_pkg::STATUS_OK;
                        start_next = $signed(item_query.query_start);
                        if ($signed(item_query.query_length) < $signed(32'sd1))
                        begin
                            len_next = LW'(1);
                        end
                        else
                        begin
                            len_next = item_query.query_length[LW-1:0];
                        end
                        np_next    = item_query.probe_count[KW-1:0];
                        k_next     = item_query.probe_index;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod_next    = prod;
                div_num_next = NW'(prod);
                div_den_next = DW'(np_reg);
                div_go_next  = 1'b1;
                state_next   = S_DIV1;
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    q1_next      = div_quot;
                    // (k + 1) * len as k * len + len
                    div_num_next = NW'(prod_reg) + NW'(len_reg);
                    div_go_next  = 1'b1;
                    state_next   = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    s_next     = XW'(start_reg) + $signed({1'b0, q1_reg});
                    e_next     = XW'(start_reg) + $signed({1'b0, div_quot});
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                div_num_next = s_reg[XW-1] ? '0 : s_reg[NW-1:0];
                lpos_next    = last[XW-1] ? '0 : last[NW-1:0];
                div_den_next = hop_eff;
                div_go_next  = 1'b1;
                state_next   = S_DIV3;
            end
            S_DIV3:
            begin
                if (div_done)
                begin
                    i0_next      = div_quot;
                    div_num_next = lpos_reg;
                    div_go_next  = 1'b1;
                    state_next   = S_DIV4;
                end
            end
            S_DIV4:
            begin
                if (div_done)
                begin
                    i1_next    = div_quot;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((pc_reg == '0) || (i0_reg > i1c))
                begin
                    amin_next  = '0;
                    amax_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = i0_reg[AW-1:0];
                    end_next   = i1c[AW-1:0];
                    any_next   = 1'b0;
                    state_next = S_RADDR;
                end
            end
            S_RADDR:
            begin
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                if (!any_reg || (emin < amin_reg))
                begin
                    amin_next = emin;
                end
                if (!any_reg || (emax > amax_reg))
                begin
                    amax_next = emax;
                end
                any_next = 1'b1;
                if (idx_reg == end_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RADDR;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = OUT_TW'({pc_reg, amax_reg, amin_reg});
                    ouser_next  = stat_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        start_reg   <= start_next;
        len_reg     <= len_next;
        np_reg      <= np_next;
        k_reg       <= k_next;
        prod_reg    <= prod_next;
        q1_reg      <= q1_next;
        s_reg       <= s_next;
        e_reg       <= e_next;
        lpos_reg    <= lpos_next;
        i0_reg      <= i0_next;
        i1_reg      <= i1_next;
        idx_reg     <= idx_next;
        end_reg     <= end_next;
        any_reg     <= any_next;
        amin_reg    <= amin_next;
        amax_reg    <= amax_next;
        stat_reg    <= stat_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        odata_reg   <= odata_next;
        ouser_reg   <= ouser_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rmin_reg   <= FS_POS;
            rmax_reg   <= FS_NEG;
            cnt_reg    <= '0;
            pc_reg     <= '0;
            div_go_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rmin_reg   <= rmin_next;
            rmax_reg   <= rmax_next;
            cnt_reg    <= cnt_next;
            pc_reg     <= pc_next;
            div_go_reg <= div_go_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// ----- design/waveform_peak_envelope_core.sv -----
// waveform_peak_envelope_core: top level of the min/max peak overview block
// depends on wpe_pkg, wpe_front, wpe_back (and through it wpe_ram, wpe_div)
//
// channel   direction  handshake           payload
// s_        in         s_tvalid/s_tready   s_tdata query and sample fields, s_tuser op
// m_        out        m_tvalid/m_tready   m_tdata peak fields, m_tuser status
// cfg_      in         cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// pushes are handled in the back end idle state, so samples stream at one word per
// cycle while no query is in progress; nearly all of a query's time from acceptance
// to the result register goes to the four 47 step divisions in the shared serial
// divider, plus an address and a data state per peak in span, and any m_tready wait
// reset is asynchronous and active low; the peak store holds no reset state
// a two word queue sits between front and back; the result register lets the
// back end keep draining pushes while a query result waits on m_tready

module waveform_peak_envelope_core #(
    parameter int PEAK_DEPTH  = wpe_pkg::DEF_PEAK_DEPTH,
    parameter int SAMPLE_BITS = wpe_pkg::DEF_SAMPLE_BITS,
    parameter int CW          = $clog2(PEAK_DEPTH + 1),
    parameter int IN_TW       = ((SAMPLE_BITS + wpe_pkg::QRY_W + 7) / 8) * 8,
    parameter int OUT_TW      = ((16 + CW + 7) / 8) * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // sample, query_start, query_length, probe_count, probe_index from bit 0 up
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_TW-1:0]         s_tdata,
    // operation
    input  logic                     s_tuser,
    // peak_min, peak_max, stored_peaks from bit 0 up
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_TW-1:0]        m_tdata,
    // status
    output logic                     m_tuser,
    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [7:0]               cfg_index,
    input  logic [wpe_pkg::HOP_W-1:0] cfg_data
);

    // configuration registers as written
    logic [wpe_pkg::HOP_W-1:0] hop_reg;
    logic [wpe_pkg::CH_W-1:0]  ch_reg;

    // effective values after range clamping
    logic [wpe_pkg::HOP_W-1:0] hop_eff;
    logic [wpe_pkg::CH_W-1:0]  ch_eff;
    logic [wpe_pkg::CNT_W-1:0] hop_total;

    // front to back item path
    logic                   item_valid;
    logic                   item_ready;
    logic                   item_op;
    logic [SAMPLE_BITS-1:0] item_sample;
    wpe_pkg::query_t        item_query;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_reg <= wpe_pkg::HOP_RESET;
            ch_reg  <= wpe_pkg::CH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wpe_pkg::REG_HOP_LENGTH:    hop_reg <= cfg_data;
                wpe_pkg::REG_CHANNEL_COUNT: ch_reg  <= cfg_data[wpe_pkg::CH_W-1:0];
                default:                    ;
            endcase
        end
    end

    // zero counts as one, oversize values saturate
    always_comb
    begin
        hop_eff = hop_reg;
        if (hop_reg == '0)
        begin
            hop_eff = wpe_pkg::HOP_W'(1);
        end
        else if (hop_reg > wpe_pkg::HOP_MAX)
        begin
            hop_eff = wpe_pkg::HOP_MAX;
        end
        ch_eff = ch_reg;
        if (ch_reg == '0)
        begin
            ch_eff = wpe_pkg::CH_W'(1);
        end
        else if (ch_reg > wpe_pkg::CH_MAX)
        begin
            ch_eff = wpe_pkg::CH_MAX;
        end
        // samples per hop across all channels, at most 2^19
        hop_total = wpe_pkg::CNT_W'(hop_eff) * wpe_pkg::CNT_W'(ch_eff);
    end

    wpe_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_TW       (IN_TW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item_op     (item_op),
        .item_sample (item_sample),
        .item_query  (item_query)
    );

    wpe_back #(
        .PEAK_DEPTH  (PEAK_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CW          (CW),
        .OUT_TW      (OUT_TW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .hop_eff     (hop_eff),
        .hop_total   (hop_total),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item_op     (item_op),
        .item_sample (item_sample),
        .item_query  (item_query),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ----- design/wpe_checker.sv -----
// wpe_checker: port level checks of the peak envelope core, bound to the top level
// depends on wpe_pkg, waveform_peak_envelope_core

module wpe_checker #(
    parameter int PEAK_DEPTH = wpe_pkg::DEF_PEAK_DEPTH,
    parameter int CW         = $clog2(PEAK_DEPTH + 1),
    parameter int OUT_TW     = ((16 + CW + 7) / 8) * 8
) (
    input logic              clk,
    input logic              rst_n,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_TW-1:0] m_tdata,
    input logic              m_tuser
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // a bad probe count gives zero peaks
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == wpe_pkg::STATUS_BAD_PROBE) |-> m_tdata[15:0] == 16'd0)
        else $error("bad probe result carries peaks");

    // minimum never above maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[7:0]) <= $signed(m_tdata[15:8]))
        else $error("peak_min above peak_max");

    // store fill never exceeds its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[16 +: CW] <= CW'(PEAK_DEPTH))
        else $error("stored_peaks beyond store depth");

endmodule

bind waveform_peak_envelope_core wpe_checker #(
    .PEAK_DEPTH (PEAK_DEPTH),
    .CW         (CW),
    .OUT_TW     (OUT_TW)
) u_wpe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/waveform_peak_envelope_core_tb.sv -----
// waveform_peak_envelope_core_tb: self-checking stream testbench of the peak envelope core
// depends on wpe_pkg and waveform_peak_envelope_core only
// a directed table first, then random pushes and probe queries, checked against a local model
`timescale 1ns / 100ps

module waveform_peak_envelope_core_tb;

    localparam int DEPTH      = 4096;
    localparam int WD_LIMIT   = 40000;
    localparam int HOLD_LEN   = 2000;
    localparam int SETTLE_CYC = 20;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    // one result word of the block
    typedef struct {
        logic       status;
        logic [7:0] pmin;
        logic [7:0] pmax;
        logic [12:0] count;
    } peak_res_t;

    // one input word plus an optional typed-in expectation
    typedef struct {
        logic        op;
        logic [15:0] smp;
        logic [31:0] qstart;
        logic [31:0] qlen;
        logic [15:0] nprobe;
        logic [14:0] kprobe;
        bit          fixed;
        peak_res_t   want;
    } env_word_t;

    typedef struct {
        row_kind_t  kind;
        logic [7:0] ridx;
        logic [16:0] rval;
        env_word_t  w;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [111:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [16:0] cfg_data;

    waveform_peak_envelope_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // model state of the envelope
    logic [16:0] mdl_hop;
    logic [3:0]  mdl_ch;
    int          mdl_min;
    int          mdl_max;
    logic [19:0] mdl_hop_cnt;
    logic [7:0]  mdl_store_min [DEPTH];
    logic [7:0]  mdl_store_max [DEPTH];
    int          mdl_peaks;

    env_word_t   pending_words [$];  // words waiting for the sender
    env_word_t   offered_words [$];  // words on the bus, in order of acceptance
    peak_res_t   expected_peaks [$];
    int          words_queued;
    int          words_taken;
    int          results_seen;
    int          queries_sent;
    int          mismatches;
    int          fails;
    bit          rx_no_idle;
    bit          tx_no_idle;
    bit          rx_hold;
    bit          hold_go;

    function automatic longint eff_hop();
        if (mdl_hop == 0)
            return 1;
        if (mdl_hop > 65536)
            return 65536;
        return mdl_hop;
    endfunction

    function automatic longint eff_channels();
        if (mdl_ch == 0)
            return 1;
        if (mdl_ch > 8)
            return 8;
        return mdl_ch;
    endfunction

    // v * 127 / full scale, truncated toward zero, clamped to 8 bits
    function automatic logic [7:0] to_peak8(int v);
        longint r;
        r = (longint'(v) * 127) / 32768;
        if (r > 127)
            r = 127;
        if (r < -128)
            r = -128;
        return r[7:0];
    endfunction

    function automatic void clear_running();
        mdl_min     = 32767;
        mdl_max     = -32768;
        mdl_hop_cnt = '0;
    endfunction

    function automatic void fold_sample(logic [15:0] smp);
        int     v;
        longint total;
        v = $signed(smp);
        total = eff_hop() * eff_channels();
        if (v < mdl_min)
            mdl_min = v;
        if (v > mdl_max)
            mdl_max = v;
        mdl_hop_cnt = mdl_hop_cnt + 1'b1;
        if (longint'(mdl_hop_cnt) >= total)
        begin
            // a full store drops the peak but still restarts the hop
            if (mdl_peaks < DEPTH)
            begin
                mdl_store_min[mdl_peaks] = to_peak8(mdl_min);
                mdl_store_max[mdl_peaks] = to_peak8(mdl_max);
                mdl_peaks++;
            end
            clear_running();
        end
    endfunction

    function automatic peak_res_t probe_span(env_word_t w);
        peak_res_t r;
        longint st, ln, np, k, hop, s, e, last, i0, i1;
        bit     any;
        logic signed [7:0] pmn, pmx, amin, amax;
        st  = longint'($signed(w.qstart));
        ln  = longint'($signed(w.qlen));
        np  = longint'($signed(w.nprobe));
        k   = longint'(w.kprobe);
        hop = eff_hop();
        amin = '0;
        amax = '0;
        any = 0;
        r.status = wpe_pkg::STATUS_OK;
        if (np < 1)
            r.status = wpe_pkg::STATUS_BAD_PROBE;
        else
        begin
            if (ln < 1)
                ln = 1;
            s = st + (k * ln) / np;
            e = st + ((k + 1) * ln) / np;
            last = (e > s) ? e - 1 : s;
            i0 = (s > 0 ? s : 0) / hop;
            i1 = (last > 0 ? last : 0) / hop;
            if (i1 > mdl_peaks - 1)
                i1 = mdl_peaks - 1;
            for (longint i = i0; i <= i1; i++)
            begin
                pmn = mdl_store_min[i];
                pmx = mdl_store_max[i];
                if (!any)
                begin
                    amin = pmn;
                    amax = pmx;
                    any = 1;
                end
                else
                begin
                    if (pmn < amin)
                        amin = pmn;
                    if (pmx > amax)
                        amax = pmx;
                end
            end
        end
        r.pmin  = amin;
        r.pmax  = amax;
        r.count = mdl_peaks[12:0];
        return r;
    endfunction

    // input side: update the model on every accepted word
    always @(posedge clk)
    begin
        env_word_t w;
        peak_res_t r;
        if (rst_n && s_tvalid && s_tready)
        begin
            w = offered_words.pop_front();
            words_taken++;
            if (s_tuser == wpe_pkg::OP_PUSH)
                fold_sample(s_tdata[15:0]);
            else
            begin
                r = probe_span(w);
                // typed-in rows override the model
                expected_peaks.push_back(w.fixed ? w.want : r);
                queries_sent++;
            end
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == wpe_pkg::REG_HOP_LENGTH)
                mdl_hop = cfg_data;
            else if (cfg_index == wpe_pkg::REG_CHANNEL_COUNT)
                mdl_ch = cfg_data[3:0];
        end
    end

    // output side: compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        peak_res_t x;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_peaks.size() == 0)
            begin
                fails++;
                if (mismatches < 10)
                    $display("unexpected result word: tdata %h tuser %b", m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                x = expected_peaks.pop_front();
                if (m_tuser !== x.status || m_tdata[7:0] !== x.pmin
                    || m_tdata[15:8] !== x.pmax || m_tdata[28:16] !== x.count)
                begin
                    fails++;
                    if (mismatches < 10)
                        $display({"result %0d mismatch: exp st %b min %0d max %0d cnt %0d,",
                                  " got st %b min %0d max %0d cnt %0d"},
                                 results_seen, x.status, $signed(x.pmin), $signed(x.pmax),
                                 x.count, m_tuser, $signed(m_tdata[7:0]),
                                 $signed(m_tdata[15:8]), m_tdata[28:16]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        int idle_cyc;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cyc = 0;
        else
            idle_cyc++;
        if (idle_cyc == WD_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // sender: random gap before each word, valid held until taken
    initial
    begin
        int        n;
        env_word_t w;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = wpe_pkg::OP_PUSH;
        @(posedge rst_n);
        forever
        begin
            if (pending_words.size() == 0)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                w = pending_words.pop_front();
                n = tx_no_idle ? 0 : $urandom_range(0, 6);
                if (n > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                offered_words.push_back(w);
                s_tvalid <= 1'b1;
                s_tuser  <= w.op;
                s_tdata  <= {1'b0, w.kprobe, w.nprobe, w.qlen, w.qstart, w.smp};
                @(posedge clk);
                while (!s_tready)
                    @(posedge clk);
            end
        end
    end

    // receiver: random stall per word, plus the long hold-off
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = rx_no_idle ? 0 : $urandom_range(0, 6);
            if (rx_hold)
            begin
                m_tready <= 1'b0;
                while (rx_hold)
                    @(posedge clk);
            end
            else if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // long receiver hold-off, counted here so the block backs up into its input
    initial
    begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        rx_hold = 1'b0;
    end

    task automatic queue_word(env_word_t w);
        pending_words.push_back(w);
        words_queued++;
    endtask

    // wait until every word is taken and every result is back, then let the core settle
    task automatic drain();
        while (words_taken != words_queued || expected_peaks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic env_word_t push_word(logic [15:0] smp);
        env_word_t w;
        w.op     = wpe_pkg::OP_PUSH;
        w.smp    = smp;
        w.qstart = $urandom;
        w.qlen   = $urandom;
        w.nprobe = 16'($urandom);
        w.kprobe = 15'($urandom);
        w.fixed  = 0;
        w.want   = '{wpe_pkg::STATUS_OK, 8'd0, 8'd0, 13'd0};
        return w;
    endfunction

    function automatic env_word_t query_word(logic [31:0] qs, logic [31:0] ql,
                                             logic [15:0] np, logic [14:0] k);
        env_word_t w;
        w = push_word(16'($urandom));
        w.op     = wpe_pkg::OP_QUERY;
        w.qstart = qs;
        w.qlen   = ql;
        w.nprobe = np;
        w.kprobe = k;
        return w;
    endfunction

    function automatic env_word_t fixed_query(logic [31:0] qs, logic [31:0] ql, logic [15:0] np,
                                              logic [14:0] k, logic st, logic [12:0] cnt);
        env_word_t w;
        w = query_word(qs, ql, np, k);
        w.fixed = 1;
        w.want  = '{st, 8'd0, 8'd0, cnt};
        return w;
    endfunction

    // random probe query aimed mostly at the filled part of the store
    function automatic env_word_t rand_query();
        longint hop, span;
        logic [31:0] qs, ql;
        logic [15:0] np;
        logic [14:0] k;
        hop  = eff_hop();
        span = (mdl_peaks + 2) * hop;
        if (span > 2000000)
            span = 2000000;
        qs = $urandom_range(0, 3) == 0 ? $urandom
             : 32'(longint'($urandom_range(0, 32'(span))) - 2 * hop);
        case ($urandom_range(0, 5))
            0: ql = $urandom;
            1: ql = 32'($urandom_range(0, 8)) - 4;
            default: ql = $urandom_range(1, 32'(span));
        endcase
        case ($urandom_range(0, 7))
            0: np = 16'($urandom);
            1: np = 16'($urandom_range(0, 3)) - 2;
            default: np = 16'($urandom_range(1, 8));
        endcase
        if ($urandom_range(0, 5) == 0)
            k = 15'($urandom);
        else
            k = 15'($urandom_range(0, $signed(np) > 0 && $signed(np) < 16 ? np[3:0] : 8));
        return query_word(qs, ql, np, k);
    endfunction

    function automatic dir_row_t row_w(env_word_t w);
        dir_row_t r;
        r.kind = ROW_WORD;
        r.ridx = '0;
        r.rval = '0;
        r.w    = w;
        return r;
    endfunction

    function automatic dir_row_t row_c(logic [7:0] idx, logic [16:0] val);
        dir_row_t r;
        r = row_w(push_word('0));
        r.kind = ROW_CFG;
        r.ridx = idx;
        r.rval = val;
        return r;
    endfunction

    initial
    begin
        dir_row_t  dir_table [$];
        int        phase_hop [8];
        int        phase_ch [8];
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        hold_go      = 1'b0;
        rx_no_idle   = 1'b0;
        tx_no_idle   = 1'b0;
        words_queued = 0;
        words_taken  = 0;
        results_seen = 0;
        queries_sent = 0;
        mismatches   = 0;
        fails        = 0;
        mdl_hop      = wpe_pkg::HOP_RESET;
        mdl_ch       = wpe_pkg::CH_RESET;
        mdl_peaks    = 0;
        clear_running();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed table: empty store, bad probe counts, sample extremes, field extremes,
        // register change mid-hop and out-of-range register values
        dir_table = '{
            row_w(fixed_query(32'd0, 32'd1, 16'd1, 15'd0, wpe_pkg::STATUS_OK, 13'd0)),
            row_w(fixed_query(32'd0, 32'd1, 16'd0, 15'd0, wpe_pkg::STATUS_BAD_PROBE, 13'd0)),
            row_c(wpe_pkg::REG_HOP_LENGTH, 17'd2),
            row_c(wpe_pkg::REG_CHANNEL_COUNT, 17'd1),
            row_w(push_word(16'h8000)),
            row_w(push_word(16'h7fff)),
            row_w(push_word(16'h0000)),
            row_w(push_word(16'h0000)),
            row_w(push_word(16'hffff)),
            row_w(push_word(16'h0001)),
            row_w(query_word(32'd0, 32'd6, 16'd1, 15'd0)),
            row_w(query_word(32'h8000_0000, 32'h8000_0000, 16'd1, 15'd0)),
            row_w(fixed_query(32'h7fff_ffff, 32'h7fff_ffff, 16'h7fff, 15'h7fff,
                              wpe_pkg::STATUS_OK, 13'd3)),
            row_w(fixed_query(32'd0, 32'd4, 16'h8000, 15'h7fff,
                              wpe_pkg::STATUS_BAD_PROBE, 13'd3)),
            row_w(query_word(32'd0, 32'h7fff_ffff, 16'd2, 15'd0)),
            row_c(wpe_pkg::REG_HOP_LENGTH, 17'd4),
            row_w(push_word(16'd5)),
            row_w(push_word(-16'sd5)),
            row_c(wpe_pkg::REG_HOP_LENGTH, 17'd0),
            row_w(push_word(16'd7)),
            row_c(wpe_pkg::REG_CHANNEL_COUNT, 17'd0),
            row_w(push_word(16'h4000)),
            row_w(query_word(32'hffff_fffe, 32'd100, 16'd3, 15'd1)),
            row_w(query_word(32'd1, 32'd3, 16'd2, 15'd5))
        };
        foreach (dir_table[i])
        begin
            if (dir_table[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(dir_table[i].ridx, dir_table[i].rval);
            end
            else
                queue_word(dir_table[i].w);
        end

        // random phases over several register settings, extremes among them
        phase_hop = '{1, 3, 0, 2, 131071, 65536, 5, 1};
        phase_ch  = '{1, 8, 15, 3, 8, 1, 2, 4};
        for (int p = 0; p < 8; p++)
        begin
            drain();
            write_reg(wpe_pkg::REG_HOP_LENGTH, 17'(phase_hop[p]));
            write_reg(wpe_pkg::REG_CHANNEL_COUNT, 17'(phase_ch[p]));
            rx_no_idle = (p % 3 == 1);
            tx_no_idle = (p % 3 == 2);
            if (p == 3)
                hold_go = 1'b1;
            for (int n = 0; n < 72; n++)
            begin
                // pushes mostly; during the hold-off keep offering words
                if ($urandom_range(0, 99) < 80)
                    queue_word(push_word(16'($urandom)));
                else
                    queue_word(rand_query());
                // keep the sender fed without letting the model run ahead of the bus
                while (pending_words.size() > 2)
                    @(posedge clk);
            end
        end

        // probe across the store as it stands at the end
        drain();
        rx_no_idle = 1'b1;
        tx_no_idle = 1'b1;
        queue_word(query_word(32'd0, 32'h7fff_ffff, 16'd1, 15'd0));
        queue_word(query_word(32'd4000, 32'd200, 16'd4, 15'd3));
        queue_word(query_word(32'd5000, 32'd1, 16'd1, 15'd0));

        drain();
        repeat (50) @(posedge clk);
        if (expected_peaks.size() != 0)
            fails++;
        $display("run covered %0d input words, %0d probe queries, %0d result words",
                 words_taken, queries_sent, results_seen);
        $display("store ended with %0d peaks, %0d mismatches", mdl_peaks, mismatches);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
